// ===== hdl/wfdm_pkg.sv =====
// ----------------------------------------------------------------------------
// wfdm_pkg
// Widths, register codes, reset values and transfer types shared by the
// windowed frequency and duty meter.
// ----------------------------------------------------------------------------
package wfdm_pkg;

  localparam int LEVEL_W    = 8;
  localparam int CHIDX_W    = 3;
  localparam int COUNT_W    = 16;
  localparam int RATE_W     = 20;
  localparam int CCOUNT_W   = 4;
  localparam int FREQ_W     = 27;
  localparam int DUTY_W     = 15;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;
  localparam int MAX_LANES  = 8;

  localparam int FPROD_W  = COUNT_W + RATE_W;
  localparam int FNUM_W   = FPROD_W + FRAC_W;
  localparam int DSCALE_W = 15;
  localparam int DNUM_W   = COUNT_W + DSCALE_W;

  localparam logic [DSCALE_W-1:0] DUTY_SCALE = 15'd25600;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE_HZ   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVELS = 8'd3;

  localparam logic [CCOUNT_W-1:0] RST_CHANNEL_COUNT = 4'd8;
  localparam logic [COUNT_W-1:0]  RST_WINDOW_LENGTH = 16'd1000;
  localparam logic [RATE_W-1:0]   RST_TICK_RATE_HZ  = 20'd1000;
  localparam logic [LEVEL_W-1:0]  RST_LEVELS        = 8'd0;

  typedef struct packed {
    logic [LEVEL_W-1:0] levels;
  } in_item_t;

  typedef struct packed {
    logic [CHIDX_W-1:0] channel_index;
    logic [COUNT_W-1:0] edge_total;
    logic [COUNT_W-1:0] high_total;
    logic [FREQ_W-1:0]  frequency_q8;
    logic [DUTY_W-1:0]  duty_q8;
    logic               last_of_window;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [CCOUNT_W-1:0] enabled;
    logic [COUNT_W-1:0]  window;
    logic [RATE_W-1:0]   rate;
  } meter_cfg_t;

endpackage

// ===== hdl/wfdm_stream_if.sv =====
// ----------------------------------------------------------------------------
// wfdm_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface wfdm_stream_if #(parameter type data_t = logic);

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== hdl/wfdm_counters.sv =====
// ----------------------------------------------------------------------------
// wfdm_counters
// Per-channel edge and high-level counter lanes, tick counter, previous
// levels and window end detection.
// ----------------------------------------------------------------------------
module wfdm_counters #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wfdm_pkg::meter_cfg_t          cfg,
  input  logic                          tick_en,
  input  logic [wfdm_pkg::LEVEL_W-1:0]  levels,
  input  logic                          load_prev,
  input  logic [wfdm_pkg::LEVEL_W-1:0]  prev_value,
  input  logic                          clear,
  input  logic [wfdm_pkg::CHIDX_W-1:0]  rd_ch,
  output logic                          win_end,
  output logic [wfdm_pkg::COUNT_W-1:0]  ticks,
  output logic [wfdm_pkg::COUNT_W-1:0]  rd_edge,
  output logic [wfdm_pkg::COUNT_W-1:0]  rd_high
);
  import wfdm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [LEVEL_W-1:0] prev_r;
  logic [COUNT_W-1:0] tick_r;
  logic [COUNT_W-1:0] tick_nxt;
  logic [COUNT_W-1:0] edge_w [CHANNELS];
  logic [COUNT_W-1:0] high_w [CHANNELS];
  logic [IDX_W-1:0]   rd_sel;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    localparam logic [CCOUNT_W:0] LANE_ID = (CCOUNT_W + 1)'(i);
    logic               lvl_now;
    logic               lvl_was;
    logic               lane_on;
    logic [COUNT_W-1:0] edge_r;
    logic [COUNT_W-1:0] high_r;

    if (i < MAX_LANES) begin : g_pin
      assign lvl_now = levels[i];
      assign lvl_was = prev_r[i];
    end else begin : g_none
      assign lvl_now = 1'b0;
      assign lvl_was = 1'b0;
    end

    assign lane_on = LANE_ID < {1'b0, cfg.enabled};

    always_ff @(posedge clk) begin
      if (!rst_n || clear) begin
        edge_r <= '0;
        high_r <= '0;
      end else if (tick_en && lane_on) begin
        if (lvl_now) high_r <= high_r + 1'b1;
        if (lvl_now && !lvl_was) edge_r <= edge_r + 1'b1;
      end
    end

    assign edge_w[i] = edge_r;
    assign high_w[i] = high_r;
  end

  assign tick_nxt = tick_r + 1'b1;
  assign win_end  = tick_en && ((tick_nxt >= cfg.window) || (tick_nxt == '0));
  assign ticks    = tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      prev_r <= RST_LEVELS;
    end else begin
      if (clear) begin
        tick_r <= '0;
      end else if (tick_en) begin
        tick_r <= tick_nxt;
      end
      if (load_prev) begin
        prev_r <= prev_value;
      end else if (tick_en) begin
        prev_r <= levels;
      end
    end
  end

  assign rd_sel  = IDX_W'(rd_ch);
  assign rd_edge = edge_w[rd_sel];
  assign rd_high = high_w[rd_sel];

endmodule

// ===== hdl/wfdm_divider.sv =====
// ----------------------------------------------------------------------------
// wfdm_divider
// Bit-serial restoring divider, one quotient bit per cycle; the quotient
// saturates to all ones when it does not fit.
// ----------------------------------------------------------------------------
module wfdm_divider #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 16,
  parameter int Q_W   = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   q_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      q_r   <= {q_r[Q_W-2:0], fits};
      ovf_r <= ovf_r | q_r[Q_W-1];
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = ovf_r ? '1 : q_r;

endmodule

// ===== hdl/wfdm_report.sv =====
// ----------------------------------------------------------------------------
// wfdm_report
// Window report sequencer: walks the enabled channels, forms the products,
// runs the frequency and duty dividers and holds each result for transfer.
// ----------------------------------------------------------------------------
module wfdm_report (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wfdm_pkg::meter_cfg_t          cfg,
  input  logic                          win_end,
  input  logic [wfdm_pkg::COUNT_W-1:0]  ticks,
  input  logic [wfdm_pkg::COUNT_W-1:0]  rd_edge,
  input  logic [wfdm_pkg::COUNT_W-1:0]  rd_high,
  output logic [wfdm_pkg::CHIDX_W-1:0]  rd_ch,
  output logic                          clear,
  output logic                          idle,
  wfdm_stream_if.source                 out_ch
);
  import wfdm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [CHIDX_W-1:0] ch_r;
  logic [CHIDX_W-1:0] ch_nxt;
  logic [COUNT_W-1:0] edge_r;
  logic [COUNT_W-1:0] high_r;
  logic [FPROD_W-1:0] fprod_r;
  logic [DNUM_W-1:0]  dprod_r;
  out_item_t          out_r;
  logic               div_start;
  logic               div_done;
  logic               f_busy;
  logic               d_busy;
  logic [FREQ_W-1:0]  f_q;
  logic [DUTY_W-1:0]  d_q;
  logic               last_ch;

  assign last_ch  = (CCOUNT_W'(ch_r) + 1'b1) == cfg.enabled;
  assign div_done = !f_busy && !d_busy;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    div_start = 1'b0;
    clear     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (win_end) begin
          state_nxt = S_MUL;
          ch_nxt    = '0;
        end
      end
      S_MUL: state_nxt = S_START;
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (last_ch) begin
            clear     = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      edge_r  <= rd_edge;
      high_r  <= rd_high;
      fprod_r <= FPROD_W'(rd_edge) * FPROD_W'(cfg.rate);
      dprod_r <= DNUM_W'(rd_high) * DNUM_W'(DUTY_SCALE);
    end
    if (state_r == S_DIV && div_done) begin
      out_r.channel_index  <= ch_r;
      out_r.edge_total     <= edge_r;
      out_r.high_total     <= high_r;
      out_r.frequency_q8   <= f_q;
      out_r.duty_q8        <= d_q;
      out_r.last_of_window <= last_ch;
    end
  end

  wfdm_divider #(
    .NUM_W (FNUM_W),
    .DEN_W (COUNT_W),
    .Q_W   (FREQ_W)
  ) u_freq_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      ({fprod_r, FRAC_W'(0)}),
    .den      (cfg.window),
    .busy     (f_busy),
    .quotient (f_q)
  );

  wfdm_divider #(
    .NUM_W (DNUM_W),
    .DEN_W (COUNT_W),
    .Q_W   (DUTY_W)
  ) u_duty_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (dprod_r),
    .den      (ticks),
    .busy     (d_busy),
    .quotient (d_q)
  );

  assign rd_ch        = ch_r;
  assign idle         = state_r == S_IDLE;
  assign out_ch.valid = state_r == S_OUT;
  assign out_ch.data  = out_r;

endmodule

// ===== hdl/windowed_frequency_duty_meter.sv =====
// ----------------------------------------------------------------------------
// windowed_frequency_duty_meter
// Counts high ticks and rising edges per channel over a window of sampling
// ticks and reports edge count, high count, frequency and duty per channel.
//
//   channel   direction  payload          transfer when
//   in_ch     in         in_item_t        valid && ready
//   out_ch    out        out_item_t       valid && ready
//   cfg_ch    in         cfg_item_t       valid (ready tied high)
//
// A closing tick is followed by a report for each enabled channel (plus
// output stalls), paced by the 44-step bit-serial frequency divider.
// Input ready is low during the report; results stall on out_ch.ready.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module windowed_frequency_duty_meter #(
  parameter int CHANNELS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  wfdm_stream_if.sink   cfg_ch,
  wfdm_stream_if.sink   in_ch,
  wfdm_stream_if.source out_ch
);
  import wfdm_pkg::*;

  localparam int LANE_LIMIT = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;
  localparam logic [CCOUNT_W-1:0] EN_MAX = CCOUNT_W'(LANE_LIMIT);

  logic [CCOUNT_W-1:0] cc_r;
  logic [COUNT_W-1:0]  win_r;
  logic [RATE_W-1:0]   rate_r;
  meter_cfg_t          mcfg;
  logic                cfg_wr;
  logic                load_prev;
  logic                idle;
  logic                tick_en;
  logic                win_end;
  logic                clear;
  logic [COUNT_W-1:0]  ticks;
  logic [COUNT_W-1:0]  rd_edge;
  logic [COUNT_W-1:0]  rd_high;
  logic [CHIDX_W-1:0]  rd_ch;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign load_prev    = cfg_wr && (cfg_ch.data.index == REG_INITIAL_LEVELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r   <= RST_CHANNEL_COUNT;
      win_r  <= RST_WINDOW_LENGTH;
      rate_r <= RST_TICK_RATE_HZ;
    end else if (cfg_wr) begin
      case (cfg_ch.data.index)
        REG_CHANNEL_COUNT: cc_r   <= cfg_ch.data.value[CCOUNT_W-1:0];
        REG_WINDOW_LENGTH: win_r  <= cfg_ch.data.value[COUNT_W-1:0];
        REG_TICK_RATE_HZ:  rate_r <= cfg_ch.data.value[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cc_r == '0) begin
      mcfg.enabled = CCOUNT_W'(1);
    end else if (cc_r > EN_MAX) begin
      mcfg.enabled = EN_MAX;
    end else begin
      mcfg.enabled = cc_r;
    end
    mcfg.window = (win_r == '0) ? COUNT_W'(1) : win_r;
    mcfg.rate   = rate_r;
  end

  assign in_ch.ready = idle;
  assign tick_en     = in_ch.valid && idle;

  wfdm_counters #(
    .CHANNELS (CHANNELS)
  ) u_counters (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (mcfg),
    .tick_en    (tick_en),
    .levels     (in_ch.data.levels),
    .load_prev  (load_prev),
    .prev_value (cfg_ch.data.value[LEVEL_W-1:0]),
    .clear      (clear),
    .rd_ch      (rd_ch),
    .win_end    (win_end),
    .ticks      (ticks),
    .rd_edge    (rd_edge),
    .rd_high    (rd_high)
  );

  wfdm_report u_report (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (mcfg),
    .win_end (win_end),
    .ticks   (ticks),
    .rd_edge (rd_edge),
    .rd_high (rd_high),
    .rd_ch   (rd_ch),
    .clear   (clear),
    .idle    (idle),
    .out_ch  (out_ch)
  );

endmodule
